// ----- design/wss_pkg.sv -----
// shared types and constants of the wildcard signature scanner
package wss_pkg;

   localparam int MAX_PATTERN_DEFAULT = 64;
   localparam int LEN_CMP_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_SCAN = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_EXACT    = 2'd0,
      KIND_WILDCARD = 2'd1,
      KIND_CAPTURE  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_FOUND      = 2'd0,
      ST_NOT_FOUND  = 2'd1,
      ST_NOT_UNIQUE = 2'd2,
      ST_INVALID    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_REGION_BASE    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic       cmd;
      logic [5:0] entry_index;
      logic [7:0] entry_byte;
      logic [1:0] entry_kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] location;
      logic [15:0] match_count;
   } rsp_type;

   typedef struct packed {
      logic        found;
      logic [31:0] index;
   } cap_type;

endpackage

// ----- design/wss_csr.sv -----
// configuration registers: clamped pattern length and region base
module wss_csr
   import wss_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [LEN_W-1:0]      len,
   output logic [31:0]           base
);

   logic [LEN_W-1:0]     len_ff, len_in;
   logic [31:0]          base_ff, base_in;
   logic [LEN_CMP_W-1:0] len_wide;
   logic                 write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      len_wide = LEN_CMP_W'(csr_data[6:0]);
      if (len_wide == '0) begin
         len_wide = LEN_CMP_W'(1);
      end else if (len_wide > LEN_CMP_W'(MAX_PATTERN)) begin
         len_wide = LEN_CMP_W'(MAX_PATTERN);
      end
   end

   always_comb begin
      len_in  = len_ff;
      base_in = base_ff;
      if (write) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: len_in  = LEN_W'(len_wide);
            CSR_REGION_BASE:    base_in = csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(1);
         base_ff <= '0;
      end else begin
         len_ff  <= len_in;
         base_ff <= base_in;
      end
   end

   assign len  = len_ff;
   assign base = base_ff;

endmodule

// ----- design/wss_table.sv -----
// signature table: entry bytes and kinds, exact mask and first capture entry
module wss_table
   import wss_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
   input  logic                     clock,
   input  logic                     load,
   input  req_type                  item,
   input  logic [LEN_W-1:0]         len,
   output logic [MAX_PATTERN-1:0]   exact_mask,
   output logic [MAX_PATTERN*8-1:0] value_vec,
   output cap_type                  cap
);

   logic [7:0] value_ff [MAX_PATTERN];
   logic [7:0] value_in [MAX_PATTERN];
   logic [1:0] kind_ff  [MAX_PATTERN];
   logic [1:0] kind_in  [MAX_PATTERN];

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         value_in[j] = value_ff[j];
         kind_in[j]  = kind_ff[j];
         if (load && (32'(item.entry_index) == 32'(j))) begin
            value_in[j] = item.entry_byte;
            kind_in[j]  = item.entry_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         value_ff[j] <= value_in[j];
         kind_ff[j]  <= kind_in[j];
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         exact_mask[j]      = (kind_ff[j] == KIND_EXACT);
         value_vec[8*j +: 8] = value_ff[j];
      end
   end

   // lowest capture entry inside the used length
   always_comb begin
      cap = '0;
      for (int j = MAX_PATTERN - 1; j >= 0; j--) begin
         if ((kind_ff[j] == KIND_CAPTURE) && (LEN_W'(j) < len)) begin
            cap.found = 1'b1;
            cap.index = 32'(j);
         end
      end
   end

endmodule

// ----- design/wss_scan.sv -----
// byte window, parallel compare, match counters and result build
module wss_scan
   import wss_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  req_type                  item,
   input  logic [LEN_W-1:0]         len,
   input  logic [31:0]              base,
   input  logic [MAX_PATTERN-1:0]   exact_mask,
   input  logic [MAX_PATTERN*8-1:0] value_vec,
   input  cap_type                  cap,
   output logic                     res_valid,
   output rsp_type                  res
);

   localparam int WIN_W = MAX_PATTERN * 8;

   logic [WIN_W-1:0]       win_ff, win_in;
   logic [31:0]            seen_ff, seen_in;
   logic [15:0]            matches_ff, matches_in;
   logic [31:0]            first_ff, first_in;

   logic                   scan_step;
   logic [WIN_W-1:0]       rev, aligned;
   logic [LEN_W-1:0]       amt;
   logic [MAX_PATTERN-1:0] ok;
   logic                   hit;
   logic [31:0]            seen_next, first_next;
   logic [15:0]            matches_next;

   assign scan_step = step && (item.cmd == CMD_SCAN);
   assign win_in    = {win_ff[WIN_W-9:0], item.data_byte};

   // reverse so the oldest byte of the used span lines up with entry zero
   always_comb begin
      for (int m = 0; m < MAX_PATTERN; m++) begin
         rev[8*m +: 8] = win_in[8*(MAX_PATTERN-1-m) +: 8];
      end
   end

   assign amt     = LEN_W'(MAX_PATTERN) - len;
   assign aligned = rev >> {amt, 3'b000};

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         ok[j] = (LEN_W'(j) >= len) || !exact_mask[j] ||
                 (aligned[8*j +: 8] == value_vec[8*j +: 8]);
      end
   end

   assign seen_next    = (&seen_ff) ? seen_ff : seen_ff + 32'd1;
   assign hit          = (seen_next >= 32'(len)) && (&ok);
   assign first_next   = (hit && (matches_ff == '0)) ? seen_next - 32'(len) : first_ff;
   assign matches_next = (hit && !(&matches_ff)) ? matches_ff + 16'd1 : matches_ff;

   always_comb begin
      res.match_count = matches_next;
      res.location    = '0;
      if (matches_next == '0) begin
         res.status = ST_NOT_FOUND;
      end else if (matches_next > 16'd1) begin
         res.status = ST_NOT_UNIQUE;
      end else if (cap.found) begin
         res.status   = ST_FOUND;
         res.location = base + first_next + cap.index;
      end else begin
         res.status = ST_INVALID;
      end
   end

   assign res_valid = scan_step && item.last;

   always_comb begin
      seen_in    = seen_ff;
      matches_in = matches_ff;
      first_in   = first_ff;
      if (scan_step) begin
         if (item.last) begin
            seen_in    = '0;
            matches_in = '0;
            first_in   = '0;
         end else begin
            seen_in    = seen_next;
            matches_in = matches_next;
            first_in   = first_next;
         end
      end
   end

   // window bytes older than the byte count are never compared
   always_ff @(posedge clock) begin
      if (scan_step) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         matches_ff <= '0;
         first_ff   <= '0;
      end else begin
         seen_ff    <= seen_in;
         matches_ff <= matches_in;
         first_ff   <= first_in;
      end
   end

endmodule

// ----- design/wildcard_signature_scan.sv -----
// top level of the wildcard signature scanner
//
//   channel  direction  handshake        payload
//   req      in         req_valid/stall  req_type: load entry or scan byte
//   rsp      out        rsp_valid/stall  rsp_type: status, location, count
//   csr      in         csr_valid/ready  csr_index, csr_data
//
// one item per cycle while req_stall is low; a scan byte with last passes
// through the input register and its result through the result register around the
// single window compare. reset clears the byte count, match count and first
// offset; signature entries are undefined until loaded. a stalled result holds
// the compare stage, and the input register then asserts req_stall.
module wildcard_signature_scan
   import wss_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;

   logic                     advance, take, step;
   logic [LEN_W-1:0]         len;
   logic [31:0]              base;
   logic [MAX_PATTERN-1:0]   exact_mask;
   logic [MAX_PATTERN*8-1:0] value_vec;
   cap_type                  cap;
   logic                     res_valid;
   rsp_type                  res;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
      if (advance && step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wss_csr #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .len       (len),
      .base      (base)
   );

   wss_table #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_table (
      .clock      (clock),
      .load       (step && (in_ff.cmd == CMD_LOAD)),
      .item       (in_ff),
      .len        (len),
      .exact_mask (exact_mask),
      .value_vec  (value_vec),
      .cap        (cap)
   );

   wss_scan #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_ff),
      .len        (len),
      .base       (base),
      .exact_mask (exact_mask),
      .value_vec  (value_vec),
      .cap        (cap),
      .res_valid  (res_valid),
      .res        (res)
   );

endmodule
